FILE: sv/nf3_pkg.sv
// ----------------------------------------------------------------------------
// nf3_pkg: shared constants, types and tables of the 3x3 neighborhood filter
// Sizes of the frame and planes, register codes and the reciprocal table
// used to divide a window sum by the number of samples inside the window.
// ----------------------------------------------------------------------------
package nf3_pkg;

	// frame and plane sizes
	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 4096;
	localparam int PLANE_COUNT = 3;
	localparam int SAMPLE_W    = 8;
	localparam int PIX_W       = PLANE_COUNT * SAMPLE_W;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);

	// 3x3 window
	localparam int WIN_DIM = 3;
	localparam int WIN_N   = WIN_DIM * WIN_DIM;
	localparam int CNT_W   = $clog2(WIN_N + 1);
	localparam int SUM_W   = $clog2(WIN_N * ((1 << SAMPLE_W) - 1) + 1);

	// reciprocal division: q = (sum * ceil(2^RECIP_SHIFT / n)) >> RECIP_SHIFT
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;

	// configuration port
	localparam int MODE_W     = 1;
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic MODE_AVERAGE = 1'b0;
	localparam logic MODE_MAXIMUM = 1'b1;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// control of one lane computation
	typedef struct packed {
		logic             fire;
		logic             mode;
		logic [WIN_N-1:0] ok;
	} lane_ctl_t;

	// control of the output stage
	typedef struct packed {
		logic load;
		logic frame_end;
	} merge_ctl_t;

	// ceil(2^RECIP_SHIFT / n) for the possible sample counts
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		unique case (n)
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/nf3_ram.sv
// ----------------------------------------------------------------------------
// nf3_ram: generic simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/nf3_lane.sv
// ----------------------------------------------------------------------------
// nf3_lane: window reduction for one plane
// Sums, counts and takes the maximum of the samples that the mask keeps,
// registers them, then divides the sum by the count through a reciprocal.
// ----------------------------------------------------------------------------
module nf3_lane (
	input  logic               clk,
	input  nf3_pkg::lane_ctl_t ctl,
	input  nf3_pkg::sample_t   samples [nf3_pkg::WIN_N],
	output nf3_pkg::sample_t   result
);

	logic [nf3_pkg::SUM_W-1:0]   sum;
	logic [nf3_pkg::CNT_W-1:0]   cnt;
	nf3_pkg::sample_t            mx;
	logic [nf3_pkg::SUM_W-1:0]   sum_s1;
	logic [nf3_pkg::CNT_W-1:0]   cnt_s1;
	nf3_pkg::sample_t            max_s1;
	logic                        mode_s1;
	logic [nf3_pkg::PROD_W-1:0]  prod;
	nf3_pkg::sample_t            quot;

	// masked sum, count and maximum over the window
	always_comb begin
		sum = '0;
		cnt = '0;
		mx  = '0;
		for (int i = 0; i < nf3_pkg::WIN_N; i++) begin
			if (ctl.ok[i]) begin
				sum = sum + nf3_pkg::SUM_W'(samples[i]);
				cnt = cnt + nf3_pkg::CNT_W'(1);
				if (samples[i] > mx) begin
					mx = samples[i];
				end
			end
		end
	end

	// reduction register
	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			sum_s1  <= sum;
			cnt_s1  <= cnt;
			max_s1  <= mx;
			mode_s1 <= ctl.mode;
		end
	end

	// truncating division by the sample count
	assign prod = {{nf3_pkg::RECIP_W{1'b0}}, sum_s1}
		* {{nf3_pkg::SUM_W{1'b0}}, nf3_pkg::recip(cnt_s1)};
	assign quot = prod[nf3_pkg::RECIP_SHIFT +: nf3_pkg::SAMPLE_W];

	assign result = (mode_s1 == nf3_pkg::MODE_MAXIMUM) ? max_s1 : quot;

endmodule

FILE: sv/nf3_merge.sv
// ----------------------------------------------------------------------------
// nf3_merge: output stage
// Gathers the lane results and the frame end flag into one result item
// and holds it until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module nf3_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  nf3_pkg::merge_ctl_t ctl,
	input  nf3_pkg::sample_t    lane_res [nf3_pkg::PLANE_COUNT],
	input  logic                out_stall,
	output logic                out_free,
	output logic                out_valid,
	output nf3_pkg::sample_t    res [nf3_pkg::PLANE_COUNT],
	output logic                frame_end
);

	logic valid_q;

	// the register can take a new item when empty or being drained
	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= ctl.load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_free && ctl.load) begin
			for (int p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin
				res[p] <= lane_res[p];
			end
			frame_end <= ctl.frame_end;
		end
	end

endmodule

FILE: sv/neighborhood_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// neighborhood_filter_3x3_top: 3x3 box average / maximum filter, three planes
// Raster-order pixels in, one filtered pixel per plane out, lagging one row
// and one column behind the input.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with plane0..2_value and flush. Feed
//   the frame in raster order, then one full row of flush items.
//   Output channel: out_valid / out_stall with plane0..2_result and
//   frame_end, set on the result of the frame's last pixel.
//   Configuration: cfg_we / cfg_index / cfg_data, written while idle. A
//   write of image_width or image_height restarts the frame position.
//   Results: an item gives none, one, or two when it is in the last column;
//   the input stays stalled until the item's results are in the output
//   stage. The sequencer reads the line stores at the input transfer,
//   updates them in the next cycle, and runs the three plane lanes once per
//   result, with a reduction step and then a divide step.
//   Reset clears the frame position, the window and the registers to their
//   defaults (average mode, 640x480). The line stores need no clearing.
//   A stalled receiver holds the result; the block takes the next input
//   meanwhile and waits only when a new result is ready to be written.
// ----------------------------------------------------------------------------
module neighborhood_filter_3x3_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         plane0_value,
	input  logic [7:0]                         plane1_value,
	input  logic [7:0]                         plane2_value,
	input  logic                               flush,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         plane0_result,
	output logic [7:0]                         plane1_result,
	output logic [7:0]                         plane2_result,
	output logic                               frame_end,
	input  logic                               cfg_we,
	input  logic [nf3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nf3_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_DIV} state_t;

	state_t                            state_q;
	logic                              mode_q;
	logic [nf3_pkg::WIDTH_W-1:0]       width_q;
	logic [nf3_pkg::HEIGHT_W-1:0]      height_q;
	logic [nf3_pkg::COL_W-1:0]         col_q;
	logic [nf3_pkg::ROW_W-1:0]         row_q;
	logic [nf3_pkg::COL_W-1:0]         w_m1;
	logic [nf3_pkg::ROW_W-1:0]         h_eff;
	nf3_pkg::sample_t                  cur_q [nf3_pkg::PLANE_COUNT];
	nf3_pkg::sample_t                  win_q [nf3_pkg::WIN_DIM][nf3_pkg::WIN_DIM]
		[nf3_pkg::PLANE_COUNT];
	logic                              pend_a_q;
	logic                              pend_b_q;
	logic [nf3_pkg::WIN_N-1:0]         ok_a_q;
	logic [nf3_pkg::WIN_N-1:0]         ok_b_q;
	logic                              fend_b_q;
	logic                              in_xfer;
	logic                              use_b;
	logic                              out_free;
	logic                              row_ok0;
	logic                              row_ok2;
	logic [nf3_pkg::PIX_W-1:0]         cur_pix;
	logic [nf3_pkg::PIX_W-1:0]         above_rd;
	logic [nf3_pkg::PIX_W-1:0]         two_rd;
	logic                              st_write;
	nf3_pkg::lane_ctl_t                lane_ctl;
	nf3_pkg::merge_ctl_t               merge_ctl;
	nf3_pkg::sample_t                  samples [nf3_pkg::PLANE_COUNT][nf3_pkg::WIN_N];
	nf3_pkg::sample_t                  lane_res [nf3_pkg::PLANE_COUNT];
	nf3_pkg::sample_t                  res [nf3_pkg::PLANE_COUNT];
	nf3_pkg::sample_t                  in_val [nf3_pkg::PLANE_COUNT];

	// window mask: entry ci*3+ri kept when its column and row lie inside
	function automatic logic [nf3_pkg::WIN_N-1:0] win_mask(
		input logic [nf3_pkg::WIN_DIM-1:0] col_ok,
		input logic [nf3_pkg::WIN_DIM-1:0] row_ok
	);
		logic [nf3_pkg::WIN_N-1:0] m;
		for (int ci = 0; ci < nf3_pkg::WIN_DIM; ci++) begin
			for (int ri = 0; ri < nf3_pkg::WIN_DIM; ri++) begin
				m[ci * nf3_pkg::WIN_DIM + ri] = col_ok[ci] && row_ok[ri];
			end
		end
		return m;
	endfunction

	assign in_val[0] = plane0_value;
	assign in_val[1] = plane1_value;
	assign in_val[2] = plane2_value;

	// effective frame size, zero taken as one and large values saturated
	always_comb begin
		priority if (width_q == '0) begin
			w_m1 = '0;
		end else if (width_q > nf3_pkg::WIDTH_W'(nf3_pkg::MAX_WIDTH)) begin
			w_m1 = nf3_pkg::COL_W'(nf3_pkg::MAX_WIDTH - 1);
		end else begin
			w_m1 = nf3_pkg::COL_W'(width_q - nf3_pkg::WIDTH_W'(1));
		end
		priority if (height_q == '0) begin
			h_eff = nf3_pkg::ROW_W'(1);
		end else if (height_q > nf3_pkg::HEIGHT_W'(nf3_pkg::MAX_HEIGHT)) begin
			h_eff = nf3_pkg::ROW_W'(nf3_pkg::MAX_HEIGHT);
		end else begin
			h_eff = nf3_pkg::ROW_W'(height_q);
		end
	end

	// input transfer only while idle
	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// rows of the window that lie inside the image
	assign row_ok0 = (row_q >= nf3_pkg::ROW_W'(2));
	assign row_ok2 = (row_q != h_eff);

	// line stores: read at the accepted column, rewritten in the next cycle
	assign st_write = (state_q == S_READ);
	always_comb begin
		for (int p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin
			cur_pix[p * nf3_pkg::SAMPLE_W +: nf3_pkg::SAMPLE_W] = cur_q[p];
		end
	end

	nf3_ram #(
		.WIDTH(nf3_pkg::PIX_W),
		.DEPTH(nf3_pkg::MAX_WIDTH)
	) u_row_above (
		.clk  (clk),
		.we   (st_write),
		.waddr(col_q),
		.wdata(cur_pix),
		.re   (in_xfer),
		.raddr(col_q),
		.rdata(above_rd)
	);

	nf3_ram #(
		.WIDTH(nf3_pkg::PIX_W),
		.DEPTH(nf3_pkg::MAX_WIDTH)
	) u_row_two_above (
		.clk  (clk),
		.we   (st_write),
		.waddr(col_q),
		.wdata(above_rd),
		.re   (in_xfer),
		.raddr(col_q),
		.rdata(two_rd)
	);

	// sequencer, frame position, window and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= nf3_pkg::MODE_AVERAGE;
			width_q  <= nf3_pkg::WIDTH_W'(640);
			height_q <= nf3_pkg::HEIGHT_W'(480);
			col_q    <= '0;
			row_q    <= '0;
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
			ok_a_q   <= '0;
			ok_b_q   <= '0;
			fend_b_q <= 1'b0;
			for (int p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin
				cur_q[p] <= '0;
			end
			for (int ci = 0; ci < nf3_pkg::WIN_DIM; ci++) begin
				for (int ri = 0; ri < nf3_pkg::WIN_DIM; ri++) begin
					for (int p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin
						win_q[ci][ri][p] <= '0;
					end
				end
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						for (int p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin
							cur_q[p] <= flush ? '0 : in_val[p];
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// shift the window and take the new column
					for (int p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin
						for (int ri = 0; ri < nf3_pkg::WIN_DIM; ri++) begin
							win_q[0][ri][p] <= win_q[1][ri][p];
							win_q[1][ri][p] <= win_q[2][ri][p];
						end
						win_q[2][0][p] <= two_rd[p * nf3_pkg::SAMPLE_W +: nf3_pkg::SAMPLE_W];
						win_q[2][1][p] <= above_rd[p * nf3_pkg::SAMPLE_W +: nf3_pkg::SAMPLE_W];
						win_q[2][2][p] <= cur_q[p];
					end
					// results due: the column before, and the last column itself
					pend_a_q <= (row_q != '0) && (col_q != '0);
					pend_b_q <= (row_q != '0) && (col_q == w_m1);
					ok_a_q   <= win_mask({1'b1, 1'b1, (col_q >= nf3_pkg::COL_W'(2))},
						{row_ok2, 1'b1, row_ok0});
					ok_b_q   <= win_mask({1'b1, (col_q != '0), 1'b0},
						{row_ok2, 1'b1, row_ok0});
					fend_b_q <= (row_q == h_eff);
					if ((row_q != '0) && ((col_q != '0) || (col_q == w_m1))) begin
						state_q <= S_CALC;
					end else begin
						state_q <= S_IDLE;
					end
					// advance the frame position
					if (col_q == w_m1) begin
						col_q <= '0;
						row_q <= (row_q == h_eff) ? '0 : row_q + nf3_pkg::ROW_W'(1);
					end else begin
						col_q <= col_q + nf3_pkg::COL_W'(1);
					end
				end
				S_CALC: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (out_free) begin
						if (!use_b) begin
							pend_a_q <= 1'b0;
							state_q  <= pend_b_q ? S_CALC : S_IDLE;
						end else begin
							pend_b_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// register writes; a size write restarts the frame
			if (cfg_we) begin
				unique case (cfg_index)
					nf3_pkg::REG_MODE: begin
						mode_q <= cfg_data[0];
					end
					nf3_pkg::REG_WIDTH, nf3_pkg::REG_HEIGHT: begin
						if (cfg_index == nf3_pkg::REG_WIDTH) begin
							width_q <= cfg_data[nf3_pkg::WIDTH_W-1:0];
						end else begin
							height_q <= cfg_data[nf3_pkg::HEIGHT_W-1:0];
						end
						col_q <= '0;
						row_q <= '0;
						for (int ci = 0; ci < nf3_pkg::WIN_DIM; ci++) begin
							for (int ri = 0; ri < nf3_pkg::WIN_DIM; ri++) begin
								for (int p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin
									win_q[ci][ri][p] <= '0;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// current result: the column before first, the last column second
	assign use_b = !pend_a_q;

	assign lane_ctl.fire = (state_q == S_CALC);
	assign lane_ctl.mode = mode_q;
	assign lane_ctl.ok   = use_b ? ok_b_q : ok_a_q;

	assign merge_ctl.load      = (state_q == S_DIV);
	assign merge_ctl.frame_end = use_b && fend_b_q;

	// plane lanes over the shared window
	always_comb begin
		for (int p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin
			for (int ci = 0; ci < nf3_pkg::WIN_DIM; ci++) begin
				for (int ri = 0; ri < nf3_pkg::WIN_DIM; ri++) begin
					samples[p][ci * nf3_pkg::WIN_DIM + ri] = win_q[ci][ri][p];
				end
			end
		end
	end

	for (genvar p = 0; p < nf3_pkg::PLANE_COUNT; p++) begin : g_lane
		nf3_lane u_lane (
			.clk    (clk),
			.ctl    (lane_ctl),
			.samples(samples[p]),
			.result (lane_res[p])
		);
	end

	// output stage
	nf3_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (merge_ctl),
		.lane_res (lane_res),
		.out_stall(out_stall),
		.out_free (out_free),
		.out_valid(out_valid),
		.res      (res),
		.frame_end(frame_end)
	);

	assign plane0_result = res[0];
	assign plane1_result = res[1];
	assign plane2_result = res[2];

`ifndef SYNTHESIS
	// the store update cycle always follows an input transfer
	a_read_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> $past(in_xfer))
		else $error("line store update without input transfer");

	// frame position stays inside the effective frame and its flush row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_m1)
		else $error("column position beyond image width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_eff)
		else $error("row position beyond flush row");

	// a result appears only from the divide step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DIV))
		else $error("result valid without a lane computation");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 neighborhood filter
// Feeds raster-order frames of three planes, each followed by its flush
// row unless cut short, under both filter modes and many frame sizes.
// Every output transfer is checked against the directed table or a
// line-store and window model kept in step with the input. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
	import nf3_pkg::*;

	localparam int LIMIT_CYCLES  = 2000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_ITEMS  = 1040;
	localparam int REPORT_CAP    = 40;
	localparam int DIR_LEN       = 32;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		sample_t plane0;
		sample_t plane1;
		sample_t plane2;
		logic    frame_end;
	} filt_res_t;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	// one line of the directed stimulus table
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		sample_t               v0;
		sample_t               v1;
		sample_t               v2;
		logic                  fl;
		logic                  typed;
		logic [1:0]            nexp;
		filt_res_t             e0;
		filt_res_t             e1;
	} stim_row_t;

	localparam filt_res_t NO_RES = '0;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            plane0_value;
	logic [7:0]            plane1_value;
	logic [7:0]            plane2_value;
	logic                  flush;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            plane0_result;
	logic [7:0]            plane1_result;
	logic [7:0]            plane2_result;
	logic                  frame_end;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// filter model state
	bit                    cfg_mode   = MODE_AVERAGE;
	bit [WIDTH_W-1:0]      cfg_width  = 12'd640;
	bit [HEIGHT_W-1:0]     cfg_height = 13'd480;
	bit [7:0]              line_above     [PLANE_COUNT][MAX_WIDTH];
	bit [7:0]              line_two_above [PLANE_COUNT][MAX_WIDTH];
	bit [7:0]              win_cols [WIN_DIM][WIN_DIM][PLANE_COUNT];
	int unsigned           col_pos;
	int unsigned           row_pos;

	filt_res_t             expected_pixels[$];
	stim_row_t             directed [DIR_LEN];
	bit                    no_idle;
	bit                    hold_long;
	int                    mismatches;
	int                    pixels_sent;
	int                    results_seen;
	int                    frames_done;
	int                    reg_writes;
	int                    cycle_count;

	neighborhood_filter_3x3_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.plane0_value  (plane0_value),
		.plane1_value  (plane1_value),
		.plane2_value  (plane2_value),
		.flush         (flush),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.plane0_result (plane0_result),
		.plane1_result (plane1_result),
		.plane2_result (plane2_result),
		.frame_end     (frame_end),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("neighborhood_filter_3x3_top regression: fail");
			$finish;
		end
	end

	// random gap length: mostly none or short, a few long
	function int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sample value with the extremes weighted up
	function sample_t rnd_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function int unsigned eff_width();
		if (cfg_width == 0)
			return 1;
		if (cfg_width > MAX_WIDTH)
			return MAX_WIDTH;
		return cfg_width;
	endfunction

	function int unsigned eff_height();
		if (cfg_height == 0)
			return 1;
		if (cfg_height > MAX_HEIGHT)
			return MAX_HEIGHT;
		return cfg_height;
	endfunction

	// average or maximum over window columns col_lo..2 and the rows in ok
	function automatic filt_res_t window_result(int col_lo, bit [2:0] ok, bit fend);
		int unsigned sum;
		int unsigned cnt;
		bit [7:0]    mx;
		bit [7:0]    s;
		bit [7:0]    outv [PLANE_COUNT];
		filt_res_t   q;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			sum = 0;
			cnt = 0;
			mx  = 0;
			for (int ci = col_lo; ci < WIN_DIM; ci++) begin
				for (int ri = 0; ri < WIN_DIM; ri++) begin
					if (ok[ri]) begin
						s = win_cols[ci][ri][p];
						sum += s;
						cnt++;
						if (s > mx)
							mx = s;
					end
				end
			end
			if (cnt == 0)
				cnt = 1;
			outv[p] = (cfg_mode == MODE_MAXIMUM) ? mx : 8'(sum / cnt);
		end
		q.plane0    = outv[0];
		q.plane1    = outv[1];
		q.plane2    = outv[2];
		q.frame_end = fend;
		return q;
	endfunction

	// advance the model by one pixel transfer; returns the number of results
	function automatic int filter_step(sample_t v0, sample_t v1, sample_t v2, bit fl,
		output filt_res_t res [2]);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int          n;
		bit [7:0]    smp [PLANE_COUNT];
		bit [7:0]    cur;
		bit [2:0]    ok;
		w = eff_width();
		h = eff_height();
		c = col_pos;
		r = row_pos;
		if (c >= w)
			c = w - 1;
		if (r > h)
			r = h;
		smp[0] = v0;
		smp[1] = v1;
		smp[2] = v2;
		// shift the window and load the new column from the line stores
		for (int ci = 0; ci < WIN_DIM - 1; ci++)
			for (int ri = 0; ri < WIN_DIM; ri++)
				for (int p = 0; p < PLANE_COUNT; p++)
					win_cols[ci][ri][p] = win_cols[ci + 1][ri][p];
		for (int p = 0; p < PLANE_COUNT; p++) begin
			cur = fl ? 8'h00 : smp[p];
			win_cols[2][0][p] = line_two_above[p][c];
			win_cols[2][1][p] = line_above[p][c];
			win_cols[2][2][p] = cur;
			line_two_above[p][c] = line_above[p][c];
			line_above[p][c] = cur;
		end
		n = 0;
		if (r >= 1) begin
			ok[0] = (r >= 2);
			ok[1] = 1'b1;
			ok[2] = (r < h);
			if (c >= 1) begin
				res[n] = window_result((c >= 2) ? 0 : 1, ok, 1'b0);
				n++;
			end
			if (c == w - 1) begin
				res[n] = window_result((c >= 1) ? 1 : 2, ok, r == h);
				n++;
			end
		end
		// next position, wrapping after the flush row
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r > h)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
		return n;
	endfunction

	function filt_res_t px(sample_t a, sample_t b, sample_t c, logic fe);
		filt_res_t q;
		q.plane0    = a;
		q.plane1    = b;
		q.plane2    = c;
		q.frame_end = fe;
		return q;
	endfunction

	function stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t s;
		s      = '0;
		s.kind = ROW_CFG;
		s.idx  = idx;
		s.data = data;
		return s;
	endfunction

	function stim_row_t pix_row(sample_t a, sample_t b, sample_t c, logic fl);
		stim_row_t s;
		s      = '0;
		s.kind = ROW_PIX;
		s.v0   = a;
		s.v1   = b;
		s.v2   = c;
		s.fl   = fl;
		return s;
	endfunction

	function stim_row_t pix_exp(sample_t a, sample_t b, sample_t c, logic fl,
		logic [1:0] n, filt_res_t e0, filt_res_t e1);
		stim_row_t s;
		s       = pix_row(a, b, c, fl);
		s.typed = 1'b1;
		s.nexp  = n;
		s.e0    = e0;
		s.e1    = e1;
		return s;
	endfunction

	// one pixel transfer, then its expected results go into the queue
	task automatic feed(input stim_row_t row);
		filt_res_t res [2];
		int        n;
		int        g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid     <= 1'b1;
		plane0_value <= row.v0;
		plane1_value <= row.v1;
		plane2_value <= row.v2;
		flush        <= row.fl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n = filter_step(row.v0, row.v1, row.v2, row.fl, res);
		if (row.typed) begin
			n      = row.nexp;
			res[0] = row.e0;
			res[1] = row.e1;
		end
		for (int k = 0; k < n; k++)
			expected_pixels = {expected_pixels, res[k]};
		pixels_sent++;
	endtask

	// register write once the block has gone idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE: cfg_mode = data[0];
			REG_WIDTH, REG_HEIGHT: begin
				if (idx == REG_WIDTH)
					cfg_width = data[WIDTH_W-1:0];
				else
					cfg_height = data[HEIGHT_W-1:0];
				col_pos = 0;
				row_pos = 0;
				foreach (win_cols[a, b, c])
					win_cols[a][b][c] = 8'h00;
			end
			default: ;
		endcase
		reg_writes++;
	endtask

	// a frame of random pixels plus its flush row, optionally cut short
	task automatic feed_frame(input int cut);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		logic        fl;
		w     = eff_width();
		h     = eff_height();
		total = (h + 1) * w;
		for (int unsigned i = 0; i < total; i++) begin
			if (cut > 0 && i >= cut)
				break;
			if (i / w < h)
				fl = ($urandom_range(0, 19) == 0);
			else
				fl = ($urandom_range(0, 6) != 0);
			feed(pix_row(rnd_sample(), rnd_sample(), rnd_sample(), fl));
		end
	endtask

	// receiver: random stalls, and one long hold-off on request
	initial begin
		int run;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_long = 1'b0;
			end else begin
				run = pick_gap();
				out_stall <= 1'b0;
				@(posedge clk);
				if (run > 0) begin
					out_stall <= 1'b1;
					repeat (run) @(posedge clk);
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		filt_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$error("result transfer with nothing expected: plane0_result %0d",
						plane0_result);
			end else begin
				want = expected_pixels.pop_front();
				if (plane0_result !== want.plane0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("plane0_result: expected %0d, got %0d", want.plane0,
							plane0_result);
				end
				if (plane1_result !== want.plane1) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("plane1_result: expected %0d, got %0d", want.plane1,
							plane1_result);
				end
				if (plane2_result !== want.plane2) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("plane2_result: expected %0d, got %0d", want.plane2,
							plane2_result);
				end
				if (frame_end !== want.frame_end) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$error("frame_end: expected %0d, got %0d", want.frame_end,
							frame_end);
				end
				if (want.frame_end)
					frames_done++;
			end
		end
	end

	// stimulus
	initial begin
		int budget;
		int sel;
		logic [CFG_DATA_W-1:0] w_data;
		logic [CFG_DATA_W-1:0] h_data;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		plane0_value <= 8'h00;
		plane1_value <= 8'h00;
		plane2_value <= 8'h00;
		flush        <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_MODE;
		cfg_data     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			// zero sizes clamp to a single pixel: the result is the pixel itself
			cfg_row(REG_WIDTH, 13'd0),
			cfg_row(REG_HEIGHT, 13'd0),
			pix_exp(8'd255, 8'd0, 8'd170, 1'b0, 2'd0, NO_RES, NO_RES),
			pix_exp(8'd90, 8'd90, 8'd90, 1'b1, 2'd1, px(8'd255, 8'd0, 8'd170, 1'b1),
				NO_RES),
			cfg_row(REG_MODE, 13'd1),
			pix_exp(8'd0, 8'd255, 8'd85, 1'b0, 2'd0, NO_RES, NO_RES),
			pix_exp(8'd17, 8'd34, 8'd51, 1'b1, 2'd1, px(8'd0, 8'd255, 8'd85, 1'b1),
				NO_RES),
			// index past the register list is dropped
			cfg_row(REG_UNUSED, 13'h1FFF),
			// 2x2 full-scale frame averages back to full scale
			cfg_row(REG_MODE, 13'd0),
			cfg_row(REG_WIDTH, 13'd2),
			cfg_row(REG_HEIGHT, 13'd2),
			pix_exp(8'd255, 8'd255, 8'd255, 1'b0, 2'd0, NO_RES, NO_RES),
			pix_exp(8'd255, 8'd255, 8'd255, 1'b0, 2'd0, NO_RES, NO_RES),
			pix_exp(8'd255, 8'd255, 8'd255, 1'b0, 2'd0, NO_RES, NO_RES),
			pix_exp(8'd255, 8'd255, 8'd255, 1'b0, 2'd2,
				px(8'd255, 8'd255, 8'd255, 1'b0), px(8'd255, 8'd255, 8'd255, 1'b0)),
			pix_exp(8'd0, 8'd0, 8'd0, 1'b1, 2'd0, NO_RES, NO_RES),
			pix_exp(8'd0, 8'd0, 8'd0, 1'b1, 2'd2,
				px(8'd255, 8'd255, 8'd255, 1'b0), px(8'd255, 8'd255, 8'd255, 1'b1)),
			// 3x3 maximum, flush inside the image, live pixel in the flush row
			cfg_row(REG_MODE, 13'd1),
			cfg_row(REG_WIDTH, 13'd3),
			cfg_row(REG_HEIGHT, 13'd3),
			pix_row(8'd12, 8'd200, 8'd0, 1'b0),
			pix_row(8'd255, 8'd1, 8'd128, 1'b0),
			pix_row(8'd3, 8'd77, 8'd254, 1'b0),
			pix_row(8'd90, 8'd90, 8'd90, 1'b0),
			pix_row(8'd201, 8'd202, 8'd203, 1'b1),
			pix_row(8'd0, 8'd255, 8'd64, 1'b0),
			pix_row(8'd128, 8'd127, 8'd1, 1'b0),
			pix_row(8'd254, 8'd253, 8'd2, 1'b0),
			pix_row(8'd7, 8'd8, 8'd9, 1'b0),
			pix_row(8'd0, 8'd0, 8'd0, 1'b1),
			pix_row(8'd255, 8'd255, 8'd255, 1'b0),
			pix_row(8'd33, 8'd44, 8'd55, 1'b1)
		};
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_reg(directed[i].idx, directed[i].data);
			else
				feed(directed[i]);
		end

		// receiver holds off while the sender keeps offering a full frame
		no_idle = 1'b1;
		write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
		write_reg(REG_WIDTH, 13'd8);
		write_reg(REG_HEIGHT, 13'd6);
		hold_long = 1'b1;
		feed_frame(0);
		no_idle = 1'b0;

		// saturated width: the start of the first row
		write_reg(REG_WIDTH, 13'hFFF);
		write_reg(REG_HEIGHT, 13'd2);
		feed_frame(6);

		// saturated height: the first rows only
		write_reg(REG_HEIGHT, 13'h1FFF);
		write_reg(REG_WIDTH, 13'd3);
		feed_frame(14);

		// random phases of small frames, some cut short
		budget = pixels_sent + RANDOM_ITEMS;
		while (pixels_sent < budget) begin
			no_idle = ($urandom_range(0, 4) == 0);
			sel = $urandom_range(0, 19);
			if (sel == 0)
				w_data = 13'd0;
			else if (sel < 14)
				w_data = CFG_DATA_W'($urandom_range(1, 6));
			else
				w_data = CFG_DATA_W'($urandom_range(7, 20));
			if ($urandom_range(0, 9) == 0)
				w_data[WIDTH_W] = 1'b1;
			sel = $urandom_range(0, 19);
			if (sel == 0)
				h_data = 13'd0;
			else if (sel < 16)
				h_data = CFG_DATA_W'($urandom_range(1, 5));
			else
				h_data = CFG_DATA_W'($urandom_range(6, 10));
			if ($urandom_range(0, 1))
				write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 8191)));
			sel = $urandom_range(0, 9);
			if (sel == 1)
				write_reg(REG_WIDTH, w_data);
			else if (sel == 2)
				write_reg(REG_HEIGHT, h_data);
			else if (sel > 2 && sel < 6) begin
				write_reg(REG_WIDTH, w_data);
				write_reg(REG_HEIGHT, h_data);
			end else if (sel >= 6) begin
				write_reg(REG_HEIGHT, h_data);
				write_reg(REG_WIDTH, w_data);
			end
			if ($urandom_range(0, 19) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
			repeat ($urandom_range(1, 3))
				feed_frame(($urandom_range(0, 6) == 0) ? $urandom_range(1, 12) : 0);
		end

		// drain
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d pixel transfers and %0d result transfers in both modes",
			pixels_sent, results_seen);
		$display("%0d frames closed, %0d register writes, %0d mismatches", frames_done,
			reg_writes, mismatches);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("neighborhood_filter_3x3_top regression: pass");
		else
			$display("neighborhood_filter_3x3_top regression: fail");
		$finish;
	end

endmodule
